>>> rtl/core/jsv_pkg.sv
// package with phase, status and type codes and the literal spelling tables for the validator
`default_nettype none
package jsv_pkg;

	// parser phases
	localparam logic [3:0] PH_LEAD    = 4'd0;
	localparam logic [3:0] PH_LIT     = 4'd1;
	localparam logic [3:0] PH_SIGN    = 4'd2;
	localparam logic [3:0] PH_ZERO    = 4'd3;
	localparam logic [3:0] PH_INT     = 4'd4;
	localparam logic [3:0] PH_DOT     = 4'd5;
	localparam logic [3:0] PH_FRAC    = 4'd6;
	localparam logic [3:0] PH_EXP     = 4'd7;
	localparam logic [3:0] PH_EXPSIGN = 4'd8;
	localparam logic [3:0] PH_EXPDIG  = 4'd9;
	localparam logic [3:0] PH_TRAIL   = 4'd10;
	localparam logic [3:0] PH_DONE    = 4'd11;

	// result status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EXPECT  = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_ROOT    = 2'd3;

	// value type
	localparam logic [1:0] TY_NULL   = 2'd0;
	localparam logic [1:0] TY_TRUE   = 2'd1;
	localparam logic [1:0] TY_FALSE  = 2'd2;
	localparam logic [1:0] TY_NUMBER = 2'd3;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_EU    = 8'h45;
	localparam logic [7:0] CH_EL    = 8'h65;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_F     = 8'h66;

	// spelled length of a literal
	function automatic logic [2:0] lit_len(input logic [1:0] kind);
		logic [2:0] len;
		len = (kind == TY_FALSE) ? 3'd5 : 3'd4;
		return len;
	endfunction

	// expected byte at a position inside a literal
	function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
		logic [7:0] c;
		c = CH_NUL;
		case (kind)
			TY_NULL: begin
				case (pos)
					3'd0: c = "n";
					3'd1: c = "u";
					3'd2: c = "l";
					3'd3: c = "l";
					default: c = CH_NUL;
				endcase
			end
			TY_TRUE: begin
				case (pos)
					3'd0: c = "t";
					3'd1: c = "r";
					3'd2: c = "u";
					3'd3: c = "e";
					default: c = CH_NUL;
				endcase
			end
			TY_FALSE: begin
				case (pos)
					3'd0: c = "f";
					3'd1: c = "a";
					3'd2: c = "l";
					3'd3: c = "s";
					3'd4: c = "e";
					default: c = CH_NUL;
				endcase
			end
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/json_scalar_validator_top.sv
// top level of the json scalar validator: input register, parser state step and result register
`default_nettype none
// Checks one JSON scalar per text. The text arrives one byte per item on the slave
// stream, and a zero byte ends it. Leading and trailing whitespace (space, tab, line
// feed, carriage return) is skipped; in between must stand exactly one of null, true,
// false or a number (optional minus, 0 or a nonzero digit and more digits, optional
// fraction, optional exponent with optional sign). Only the end byte gives a result
// item: status in bits 1:0 (0 ok, 1 expect value, 2 invalid value, 3 root not singular)
// and value type in bits 3:2 (0 null, 1 true, 2 false, 3 number; null unless ok). The
// first fault decides the status and later bytes up to the end byte are ignored. After
// the end byte the parser is back in its reset state. Throughput is one byte per cycle:
// a byte is taken into an input register, the parser state advances in the next cycle
// through a shallow character classifier, and results land in an output register.
// Only an end byte waiting on a full, stalled result register holds the input back.
module json_scalar_validator_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // ch[7:0]
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata    // status[1:0], value_type[3:2], zero[7:4]
);
	import jsv_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] ch_s1;

	// parser state
	logic [3:0] phase_q, phase_d;
	logic [2:0] lit_pos_q, lit_pos_d;
	logic [1:0] lit_kind_q, lit_kind_d;
	logic [1:0] held_status_q, held_status_d;
	logic [1:0] held_type_q, held_type_d;

	// result register
	logic       out_valid_q;
	logic [1:0] status_q, res_status;
	logic [1:0] type_q, res_type;

	logic advance;
	logic is_end;
	logic is_ws, is_digit, is_exp;
	logic [1:0] k;
	logic [2:0] p_next;

	assign is_end   = (ch_s1 == CH_NUL);
	assign is_ws    = (ch_s1 == CH_SPACE) || (ch_s1 == CH_TAB) ||
	                  (ch_s1 == CH_LF) || (ch_s1 == CH_CR);
	assign is_digit = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
	assign is_exp   = (ch_s1 == CH_EL) || (ch_s1 == CH_EU);

	// an end byte only moves on when the result register can take its result
	assign advance = valid_s1 && (!is_end || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// kind code three falls back to null, as the literal tables only know three kinds
	assign k      = (lit_kind_q == TY_NUMBER) ? TY_NULL : lit_kind_q;
	assign p_next = lit_pos_q + 3'd1;

	// one parser step for the byte in the input register
	always_comb begin
		phase_d       = phase_q;
		lit_pos_d     = lit_pos_q;
		lit_kind_d    = lit_kind_q;
		held_status_d = held_status_q;
		held_type_d   = held_type_q;
		res_status    = ST_EXPECT;
		res_type      = TY_NULL;

		if (is_end) begin
			// verdict for the whole text
			unique case (phase_q) inside
				PH_TRAIL, PH_DONE: begin
					res_status = held_status_q;
					res_type   = held_type_q;
				end
				PH_ZERO, PH_INT, PH_FRAC, PH_EXPDIG: begin
					res_status = ST_OK;
					res_type   = TY_NUMBER;
				end
				PH_LIT, PH_SIGN, PH_DOT, PH_EXP, PH_EXPSIGN: begin
					res_status = ST_INVALID;
				end
				default: begin
					res_status = ST_EXPECT;
				end
			endcase
			if (res_status != ST_OK)
				res_type = TY_NULL;
			// back to the reset state
			phase_d       = PH_LEAD;
			lit_pos_d     = 3'd0;
			lit_kind_d    = TY_NULL;
			held_status_d = ST_OK;
			held_type_d   = TY_NULL;
		end else begin
			unique case (phase_q) inside
				PH_LIT: begin
					if ((lit_pos_q < lit_len(k)) && (ch_s1 == lit_char(k, lit_pos_q))) begin
						lit_pos_d = p_next;
						if (p_next >= lit_len(k)) begin
							held_status_d = ST_OK;
							held_type_d   = k;
							phase_d       = PH_TRAIL;
						end
					end else begin
						held_status_d = ST_INVALID;
						held_type_d   = TY_NULL;
						phase_d       = PH_DONE;
					end
				end
				PH_SIGN, PH_DOT, PH_EXPSIGN: begin
					// a digit is mandatory here
					if (phase_q == PH_SIGN && ch_s1 == CH_ZERO)
						phase_d = PH_ZERO;
					else if (is_digit)
						phase_d = (phase_q == PH_SIGN) ? PH_INT :
						          (phase_q == PH_DOT)  ? PH_FRAC : PH_EXPDIG;
					else begin
						held_status_d = ST_INVALID;
						held_type_d   = TY_NULL;
						phase_d       = PH_DONE;
					end
				end
				PH_EXP: begin
					if (ch_s1 == CH_PLUS || ch_s1 == CH_MINUS)
						phase_d = PH_EXPSIGN;
					else if (is_digit)
						phase_d = PH_EXPDIG;
					else begin
						held_status_d = ST_INVALID;
						held_type_d   = TY_NULL;
						phase_d       = PH_DONE;
					end
				end
				PH_ZERO, PH_INT, PH_FRAC, PH_EXPDIG: begin
					if (is_digit && phase_q != PH_ZERO)
						phase_d = phase_q;
					else if (ch_s1 == CH_DOT && (phase_q == PH_ZERO || phase_q == PH_INT))
						phase_d = PH_DOT;
					else if (is_exp && phase_q != PH_EXPDIG)
						phase_d = PH_EXP;
					else begin
						// number is complete, this byte is trailing text
						held_status_d = ST_OK;
						held_type_d   = TY_NUMBER;
						if (is_ws)
							phase_d = PH_TRAIL;
						else begin
							held_status_d = ST_ROOT;
							held_type_d   = TY_NULL;
							phase_d       = PH_DONE;
						end
					end
				end
				PH_TRAIL: begin
					if (!is_ws) begin
						held_status_d = ST_ROOT;
						held_type_d   = TY_NULL;
						phase_d       = PH_DONE;
					end
				end
				PH_DONE: begin
					phase_d = PH_DONE;
				end
				default: begin
					// leading whitespace, also taken for unused codes
					if (is_ws)
						phase_d = PH_LEAD;
					else if (ch_s1 == CH_N || ch_s1 == CH_T || ch_s1 == CH_F) begin
						lit_kind_d = (ch_s1 == CH_N) ? TY_NULL :
						             (ch_s1 == CH_T) ? TY_TRUE : TY_FALSE;
						lit_pos_d  = 3'd1;
						phase_d    = PH_LIT;
					end else if (ch_s1 == CH_MINUS)
						phase_d = PH_SIGN;
					else if (ch_s1 == CH_ZERO)
						phase_d = PH_ZERO;
					else if (is_digit)
						phase_d = PH_INT;
					else begin
						held_status_d = ST_INVALID;
						held_type_d   = TY_NULL;
						phase_d       = PH_DONE;
					end
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			ch_s1 <= s_axis_tdata;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LEAD;
			lit_pos_q     <= 3'd0;
			lit_kind_q    <= TY_NULL;
			held_status_q <= ST_OK;
			held_type_q   <= TY_NULL;
		end else if (advance) begin
			phase_q       <= phase_d;
			lit_pos_q     <= lit_pos_d;
			lit_kind_q    <= lit_kind_d;
			held_status_q <= held_status_d;
			held_type_q   <= held_type_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_end) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end) begin
			status_q <= res_status;
			type_q   <= res_type;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, type_q, status_q};

	// a failed text never reports a value type
	a_type_null_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (type_q == TY_NULL))
		else $error("value type not null on a failed result");

	// an end byte produces a result and leaves the parser in its reset state
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_end) |=> (out_valid_q && phase_q == PH_LEAD && lit_pos_q == 3'd0))
		else $error("end byte did not give a result or clear the parser");

	// only an end byte ever waits in the input register
	a_stall_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> is_end)
		else $error("non-end byte stalled");

	// inside a literal the position stays within the spelling
	a_lit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LIT) |-> (lit_pos_q != 3'd0 && lit_pos_q <= 3'd4))
		else $error("literal position out of range");

endmodule
`default_nettype wire

>>> tb/sv/tb_json_scalar_validator_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the json scalar validator top level
module tb_json_scalar_validator_top;
	import jsv_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_BYTES = 400;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 60000;
	localparam int N_DIRECTED   = 8;
	localparam int N_BURST      = 12;

	// directed row expectation: {known, value_type, status}; zero means use the scanner model
	localparam logic [4:0] FROM_SCANNER = 5'd0;

	// one result item as it sits in tdata[3:0]
	typedef struct packed {
		logic [1:0] vtype;
		logic [1:0] status;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata = 8'h00;
	logic       m_tready = 1'b0;
	wire        s_tready;
	wire        m_tvalid;
	wire  [7:0] m_tdata;

	json_scalar_validator_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),   // ch[7:0]
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)    // status[1:0], value_type[3:2], zero[7:4]
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// verdicts owed by the block, oldest first
	verdict_t   verdicts_due[$];
	logic [7:0] text_q[$];

	int cycles = 0;
	int errors = 0;
	int bytes_sent = 0;
	int texts_sent = 0;
	int verdicts_checked = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int holds_served = 0;
	int gap_by_phase[4] = '{0, 53, 0, 10};
	int stall_by_phase[4] = '{0, 0, 53, 10};
	verdict_t got_v;
	verdict_t want_v;

	// directed texts; the end byte is appended by the sender
	string dir_text[N_DIRECTED] = '{
		"",             // empty text
		" \t\n\015",    // whitespace only
		"null",
		"-",            // lone minus
		"01",           // extra digit after a leading zero
		"t\377x",       // broken literal, later bytes ignored
		"-0.5E+9",
		"\377"          // top byte value as the whole text
	};
	logic [4:0] dir_expect[N_DIRECTED] = '{
		{1'b1, TY_NULL, ST_EXPECT},
		{1'b1, TY_NULL, ST_EXPECT},
		{1'b1, TY_NULL, ST_OK},
		{1'b1, TY_NULL, ST_INVALID},
		{1'b1, TY_NULL, ST_ROOT},
		{1'b1, TY_NULL, ST_INVALID},
		FROM_SCANNER,
		{1'b1, TY_NULL, ST_INVALID}
	};

	// ------------------------------------------------------------------
	// scanner model: mirrors the parser state one byte at a time
	// ------------------------------------------------------------------
	logic [3:0] scan_phase  = PH_LEAD;
	logic [2:0] lit_pos     = 3'd0;
	logic [1:0] lit_kind    = 2'd0;
	logic [1:0] held_status = ST_OK;
	logic [1:0] held_type   = TY_NULL;

	function automatic bit is_ws(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic string literal_word(input logic [1:0] kind);
		case (kind)
			TY_NULL: return "null";
			TY_TRUE: return "true";
			default: return "false";
		endcase
	endfunction

	task automatic fail_with(input logic [1:0] code);
		held_status = code;
		held_type   = TY_NULL;
		scan_phase  = PH_DONE;
	endtask

	// a byte that cannot extend the value counts as trailing text
	task automatic trail_char(input logic [7:0] c);
		if (is_ws(c)) begin
			scan_phase = PH_TRAIL;
		end else begin
			fail_with(ST_ROOT);
		end
	endtask

	task automatic number_ends(input logic [7:0] c);
		held_status = ST_OK;
		held_type   = TY_NUMBER;
		trail_char(c);
	endtask

	task automatic scan_char(input logic [7:0] c, output bit done, output verdict_t v);
		string      word;
		logic [1:0] st;
		done = 1'b0;
		v    = '0;
		if (c == CH_NUL) begin
			case (scan_phase)
				PH_TRAIL, PH_DONE: st = held_status;
				PH_ZERO, PH_INT, PH_FRAC, PH_EXPDIG: begin
					st = ST_OK;
					held_type = TY_NUMBER;
				end
				PH_LIT, PH_SIGN, PH_DOT, PH_EXP, PH_EXPSIGN: st = ST_INVALID;
				default: st = ST_EXPECT;
			endcase
			done     = 1'b1;
			v.status = st;
			v.vtype  = (st == ST_OK) ? held_type : TY_NULL;
			scan_phase  = PH_LEAD;
			lit_pos     = 3'd0;
			lit_kind    = 2'd0;
			held_status = ST_OK;
			held_type   = TY_NULL;
		end else begin
			case (scan_phase)
				PH_LIT: begin
					word = literal_word(2'(lit_kind % 3));
					if (lit_pos < word.len() && c == word[lit_pos]) begin
						lit_pos = lit_pos + 3'd1;
						if (lit_pos >= word.len()) begin
							held_status = ST_OK;
							held_type   = 2'(lit_kind % 3);
							scan_phase  = PH_TRAIL;
						end
					end else begin
						fail_with(ST_INVALID);
					end
				end
				PH_SIGN: begin
					if (c == CH_ZERO) scan_phase = PH_ZERO;
					else if (is_digit(c)) scan_phase = PH_INT;
					else fail_with(ST_INVALID);
				end
				PH_ZERO: begin
					if (c == CH_DOT) scan_phase = PH_DOT;
					else if (c == CH_EL || c == CH_EU) scan_phase = PH_EXP;
					else number_ends(c);
				end
				PH_INT: begin
					if (is_digit(c)) scan_phase = PH_INT;
					else if (c == CH_DOT) scan_phase = PH_DOT;
					else if (c == CH_EL || c == CH_EU) scan_phase = PH_EXP;
					else number_ends(c);
				end
				PH_DOT: begin
					if (is_digit(c)) scan_phase = PH_FRAC;
					else fail_with(ST_INVALID);
				end
				PH_FRAC: begin
					if (is_digit(c)) scan_phase = PH_FRAC;
					else if (c == CH_EL || c == CH_EU) scan_phase = PH_EXP;
					else number_ends(c);
				end
				PH_EXP: begin
					if (c == CH_PLUS || c == CH_MINUS) scan_phase = PH_EXPSIGN;
					else if (is_digit(c)) scan_phase = PH_EXPDIG;
					else fail_with(ST_INVALID);
				end
				PH_EXPSIGN: begin
					if (is_digit(c)) scan_phase = PH_EXPDIG;
					else fail_with(ST_INVALID);
				end
				PH_EXPDIG: begin
					if (is_digit(c)) scan_phase = PH_EXPDIG;
					else number_ends(c);
				end
				PH_TRAIL: trail_char(c);
				PH_DONE: ;
				default: begin
					// leading whitespace, and any unused phase code
					if (is_ws(c)) begin
						scan_phase = PH_LEAD;
					end else if (c == CH_N || c == CH_T || c == CH_F) begin
						lit_kind   = (c == CH_N) ? TY_NULL : (c == CH_T) ? TY_TRUE : TY_FALSE;
						lit_pos    = 3'd1;
						scan_phase = PH_LIT;
					end else if (c == CH_MINUS) begin
						scan_phase = PH_SIGN;
					end else if (c == CH_ZERO) begin
						scan_phase = PH_ZERO;
					end else if (is_digit(c)) begin
						scan_phase = PH_INT;
					end else begin
						fail_with(ST_INVALID);
					end
				end
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// text generation
	// ------------------------------------------------------------------
	function automatic logic [7:0] rand_ws();
		case ($urandom_range(3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	task automatic add_ws(input int max_n);
		repeat ($urandom_range(max_n)) text_q.push_back(rand_ws());
	endtask

	task automatic add_number();
		if ($urandom_range(1)) text_q.push_back(CH_MINUS);
		if ($urandom_range(3) == 0) begin
			text_q.push_back(CH_ZERO);
		end else begin
			text_q.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
			repeat ($urandom_range(4)) text_q.push_back(rand_digit());
		end
		if ($urandom_range(1)) begin
			text_q.push_back(CH_DOT);
			repeat ($urandom_range(1, 3)) text_q.push_back(rand_digit());
		end
		if ($urandom_range(2) == 0) begin
			text_q.push_back($urandom_range(1) ? CH_EL : CH_EU);
			case ($urandom_range(2))
				0: text_q.push_back(CH_PLUS);
				1: text_q.push_back(CH_MINUS);
				default: ;
			endcase
			repeat ($urandom_range(1, 3)) text_q.push_back(rand_digit());
		end
	endtask

	task automatic add_literal(input logic [1:0] kind, input int n);
		string word;
		word = literal_word(kind);
		for (int i = 0; i < n; i++) text_q.push_back(word[i]);
	endtask

	task automatic add_junk(input int max_n);
		repeat ($urandom_range(max_n)) text_q.push_back(8'($urandom_range(1, 255)));
	endtask

	// half well-formed values, the rest broken values, stray text, whitespace only and plain noise
	task automatic make_text();
		logic [1:0] kind;
		int         len;
		text_q.delete();
		kind = 2'($urandom_range(2));
		len  = (kind == TY_FALSE) ? 5 : 4;
		case ($urandom_range(9))
			0, 1, 2: begin
				add_ws(2);
				add_number();
				add_ws(2);
			end
			3, 4: begin
				add_ws(2);
				add_literal(kind, len);
				add_ws(2);
			end
			5: begin
				// literal cut short or misspelled, maybe followed by ignored bytes
				add_ws(1);
				add_literal(kind, $urandom_range(1, len - 1));
				add_junk(3);
			end
			6: begin
				// number cut off after a sign, dot or exponent mark
				case ($urandom_range(3))
					0: text_q.push_back(CH_MINUS);
					1: begin
						text_q.push_back(rand_digit());
						text_q.push_back(CH_DOT);
					end
					2: begin
						text_q.push_back(rand_digit());
						text_q.push_back(CH_EL);
					end
					default: begin
						text_q.push_back(rand_digit());
						text_q.push_back(CH_EU);
						text_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
					end
				endcase
				if ($urandom_range(1)) add_junk(2);
			end
			7: begin
				// complete value followed by stray bytes
				if ($urandom_range(1)) add_number();
				else add_literal(kind, len);
				add_ws(1);
				add_junk(3);
				text_q.push_back(8'($urandom_range(1, 255)));
			end
			8: add_ws(3);
			default: begin
				add_junk(5);
				text_q.push_back(8'($urandom_range(1, 255)));
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------
	task automatic push_ch(input logic [7:0] c, input logic [4:0] fixed);
		bit       taken;
		bit       done;
		verdict_t v;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		// ready is read mid-cycle, when everything has settled
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		bytes_sent++;
		scan_char(c, done, v);
		if (done) begin
			if (fixed[4]) v = fixed[3:0];
			verdicts_due.push_back(v);
			texts_sent++;
		end
	endtask

	task automatic send_text(input logic [4:0] fixed);
		foreach (text_q[i]) push_ch(text_q[i], fixed);
		push_ch(CH_NUL, fixed);
	endtask

	// sender pauses until every owed verdict has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// receiver: random stalls, plus one long hold on request
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_served) begin
				holds_served = hold_reqs;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// result checker, sampled mid-cycle ahead of the accepting edge
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [1:0] got,
			input logic [1:0] want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
	endtask

	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_v = m_tdata[3:0];
			if (verdicts_due.size() == 0) begin
				report_mismatch("unexpected result, status", got_v.status, ST_OK);
			end else begin
				want_v = verdicts_due.pop_front();
				if (got_v.status !== want_v.status)
					report_mismatch("status", got_v.status, want_v.status);
				if (got_v.vtype !== want_v.vtype)
					report_mismatch("value type", got_v.vtype, want_v.vtype);
				verdicts_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				verdicts_due.size());
			$display("** json_scalar_validator_top: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int budget;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed texts, no idling
		for (int r = 0; r < N_DIRECTED; r++) begin
			text_q.delete();
			for (int i = 0; i < dir_text[r].len(); i++) text_q.push_back(dir_text[r][i]);
			send_text(dir_expect[r]);
		end
		drain();

		// random texts under each idle mix
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct   = gap_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			budget    = bytes_sent + RANDOM_BYTES / 4;
			while (bytes_sent < budget) begin
				make_text();
				send_text(FROM_SCANNER);
			end
			if (ph == 0) begin
				// long receiver hold while short texts keep coming, so the
				// result register fills and the input backs up
				drain();
				hold_reqs <= hold_reqs + 1;
				for (int i = 0; i < N_BURST; i++) begin
					text_q.delete();
					if (i % 2 == 0) text_q.push_back(rand_digit());
					send_text(FROM_SCANNER);
				end
			end
			drain();
		end

		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d texts in %0d bytes, checked %0d results", texts_sent,
			bytes_sent, verdicts_checked);
		$display("literals, numbers, broken and stray text under four idle mixes "
			, "and one long output hold");
		if (errors == 0) begin
			$display("** json_scalar_validator_top: PASSED **");
		end else begin
			$display("** json_scalar_validator_top: FAILED **");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/jsv_pkg.sv
rtl/core/json_scalar_validator_top.sv
tb/sv/tb_json_scalar_validator_top.sv
